>>> hw/rtl/bsm_pkg.sv
// ---------------------------------------------------------------------------
// bsm_pkg: shared types and constants for the bitap substitution matcher
// Item layouts, action codes, register indexes and row-cell control.
// ---------------------------------------------------------------------------
`default_nettype none

package bsm_pkg;

    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 5;
    localparam int SYMBOL_W = 8;
    localparam int CHAR_W   = 7;
    localparam int LENGTH_W = 5;
    localparam int ERRORS_W = 3;
    localparam int POS_W    = 32;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ERRORS     = 1'b1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BEGIN = 2'd0,
        ACT_LOAD  = 2'd1,
        ACT_TEXT  = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef struct packed {
        t_action              action;
        logic [INDEX_W-1:0]   pattern_index;
        logic [SYMBOL_W-1:0]  symbol;
    } t_in;

    typedef struct packed {
        logic                 match_found;
        logic [POS_W-1:0]     match_start;
    } t_out;

    typedef struct packed {
        logic init;
        logic step;
    } t_row_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/bsm_char_cell.sv
// ---------------------------------------------------------------------------
// bsm_char_cell: one pattern character slot
// Stores one 7-bit pattern character and compares it with the text symbol.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_char_cell
    import bsm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [SYMBOL_W-1:0] i_symbol,
    input  wire logic                i_in_use,
    output logic                     o_hit
);

    logic [CHAR_W-1:0] r_char;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_char <= i_symbol[CHAR_W-1:0];
        end
    end

    // bytes above 127 never match
    assign o_hit = i_in_use && !i_symbol[SYMBOL_W-1] && (r_char == i_symbol[CHAR_W-1:0]);

endmodule

`default_nettype wire

>>> hw/rtl/bsm_row_cell.sv
// ---------------------------------------------------------------------------
// bsm_row_cell: one error row of the bitap state
// Holds row d and updates it from its own value, the mask and row d-1.
// ---------------------------------------------------------------------------
`default_nettype none

module bsm_row_cell
    import bsm_pkg::*;
#(
    parameter int ROW_W = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_row_ctl         i_ctl,
    input  wire logic [ROW_W-1:0] i_prev,
    input  wire logic [ROW_W-1:0] i_mask,
    output logic [ROW_W-1:0]      o_row,
    output logic [ROW_W-1:0]      o_next
);

    localparam logic [ROW_W-1:0] ROW_INIT = {{(ROW_W-1){1'b1}}, 1'b0};

    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] w_and;

    assign w_and  = i_prev & (r_row | i_mask);
    assign o_next = {w_and[ROW_W-2:0], 1'b0};
    assign o_row  = r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_row <= ROW_INIT;
        end else if (i_ctl.step) begin
            r_row <= o_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bitap_substitution_matcher.sv
// ---------------------------------------------------------------------------
// bitap_substitution_matcher: streaming k-mismatch pattern search
// Bitap shift-and over a chain of error-row cells and pattern-character cells.
// ---------------------------------------------------------------------------
// Takes one item per clock cycle and returns one result per item, in the cycle
// after the transfer, through a single output register. Every error row and
// every pattern compare is updated at the transfer, so the rate is one item
// per cycle whenever the output side does not stall; a stall on the output
// stalls the input in the same cycle. Load the pattern with load items, set
// pattern_length and max_errors while idle, send a begin item, then stream
// text bytes; each text byte reports whether a match ends there and its start.
`default_nettype none

module bitap_substitution_matcher
    import bsm_pkg::*;
#(
    parameter int PATTERN_MAX = 31,
    parameter int ERRORS_MAX  = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_in                  i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_out                      o_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int ROW_W = PATTERN_MAX + 1;
    localparam int M_W   = $clog2(PATTERN_MAX + 1);
    localparam int NROWS = ERRORS_MAX + 1;
    localparam int K_W   = (ERRORS_MAX > 0) ? $clog2(ERRORS_MAX + 1) : 1;
    localparam logic [6:0] PMAX7 = 7'(PATTERN_MAX);
    localparam logic [5:0] EMAX6 = 6'(ERRORS_MAX);

    logic [LENGTH_W-1:0] r_len;
    logic [ERRORS_W-1:0] r_err;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    n_pos;
    logic                r_valid;
    t_out                r_out;
    t_out                n_out;

    logic                w_acc;
    logic                w_begin;
    logic                w_load;
    logic                w_text;
    logic [6:0]          w_m7;
    logic [M_W-1:0]      w_m;
    logic [5:0]          w_k6;
    logic [K_W-1:0]      w_k;
    logic [ROW_W-1:0]    w_mask;
    logic [ROW_W-1:0]    w_sel;
    logic [ROW_W-1:0]    w_row_q [NROWS];
    logic [ROW_W-1:0]    w_row_d [NROWS];

    assign o_stall = r_valid && i_stall;
    assign w_acc   = i_valid && !o_stall;
    assign w_begin = w_acc && (i_data.action == ACT_BEGIN);
    assign w_load  = w_acc && (i_data.action == ACT_LOAD);
    assign w_text  = w_acc && (i_data.action == ACT_TEXT);

    always_comb begin
        w_m7 = {2'b00, r_len};
        if (w_m7 == 7'd0) begin
            w_m7 = 7'd1;
        end else if (w_m7 > PMAX7) begin
            w_m7 = PMAX7;
        end
        w_k6 = (6'(r_err) > EMAX6) ? EMAX6 : 6'(r_err);
    end

    assign w_m = M_W'(w_m7);
    assign w_k = K_W'(w_k6);

    // pattern character cells
    for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_char
        logic w_hit;
        bsm_char_cell u_char (
            .i_clk    (i_clk),
            .i_we     (w_load && ({2'b00, i_data.pattern_index} == 7'(i))),
            .i_symbol (i_data.symbol),
            .i_in_use (7'(i) < w_m7),
            .o_hit    (w_hit)
        );
        assign w_mask[i] = !w_hit;
    end
    assign w_mask[PATTERN_MAX] = 1'b1;

    // error row cells, each above row 0 fed by its lower neighbor
    for (genvar d = 0; d < NROWS; d++) begin : g_row
        t_row_ctl         w_ctl;
        logic [ROW_W-1:0] w_prev;
        assign w_ctl.init = w_begin;
        assign w_ctl.step = w_text && (6'(d) <= w_k6);
        if (d == 0) begin : g_first
            assign w_prev = '1;
        end else begin : g_rest
            assign w_prev = w_row_q[d-1];
        end
        bsm_row_cell #(
            .ROW_W (ROW_W)
        ) u_row (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_prev  (w_prev),
            .i_mask  (w_mask),
            .o_row   (w_row_q[d]),
            .o_next  (w_row_d[d])
        );
    end

    assign w_sel = w_row_d[w_k];

    always_comb begin
        n_out = '0;
        if (w_text && !w_sel[w_m]) begin
            n_out.match_found = 1'b1;
            n_out.match_start = r_pos - POS_W'(w_m) + POS_W'(1);
        end
        n_pos = r_pos;
        if (w_begin) begin
            n_pos = '0;
        end else if (w_text && (r_pos != '1)) begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= LENGTH_W'(1);
            r_err   <= '0;
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (w_acc) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PATTERN_LENGTH: r_len <= i_cfg_data[LENGTH_W-1:0];
                    CFG_MAX_ERRORS:     r_err <= i_cfg_data[ERRORS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

    a_begin_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_begin |=> (r_pos == '0))
        else $error("position not cleared by begin");

    a_text_advances_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_text && (r_pos != '1)) |=> (r_pos == $past(r_pos) + POS_W'(1)))
        else $error("position did not advance");

    a_no_match_on_control: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !(i_data.action == ACT_TEXT)) |=> !o_data.match_found)
        else $error("match reported for non-text transfer");

    a_start_zero_without_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.match_found) |-> (o_data.match_start == '0))
        else $error("start index set without match");

    a_row_bit0_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_row_q[0][0] == 1'b0)
        else $error("error row 0 bit 0 set");

endmodule

`default_nettype wire

>>> tb/sv/bitap_substitution_matcher_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bitap_substitution_matcher_checker: match predictor and result scoreboard
// Follows register writes and accepted input transfers to keep its own copy
// of the pattern, error rows and text position. It predicts one result per
// input transfer and compares every output transfer, in order, against the
// oldest prediction still waiting.
// ---------------------------------------------------------------------------
module bitap_substitution_matcher_checker
    import bsm_pkg::*;
#(
    parameter int PATTERN_MAX = 31,
    parameter int ERRORS_MAX  = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  t_in                  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  t_out                 i_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int unsigned          o_fail_count,
    output int unsigned          o_pending
);

    localparam int ROW_W = PATTERN_MAX + 1;
    localparam logic [ROW_W-1:0] ROW_START = ~ROW_W'(1);

    logic [CHAR_W-1:0]   stored_chars [PATTERN_MAX];
    logic [ROW_W-1:0]    mismatch_rows [ERRORS_MAX+1];
    logic [POS_W-1:0]    text_pos;
    logic [LENGTH_W-1:0] length_reg;
    logic [ERRORS_W-1:0] errors_reg;
    t_out                predicted_results [$];
    t_out                oldest;

    function automatic t_out match_step(input t_in item);
        t_out             res;
        logic [ROW_W-1:0] char_mask;
        logic [ROW_W-1:0] prev_row;
        logic [ROW_W-1:0] cur_row;
        logic [POS_W-1:0] pos_now;
        int unsigned      m_eff;
        int unsigned      k_eff;
        res = '0;
        case (item.action)
            ACT_BEGIN: begin
                foreach (mismatch_rows[d]) mismatch_rows[d] = ROW_START;
                text_pos = '0;
            end
            ACT_LOAD: begin
                if (item.pattern_index < PATTERN_MAX)
                    stored_chars[item.pattern_index] = item.symbol[CHAR_W-1:0];
            end
            ACT_TEXT: begin
                m_eff = (length_reg == 0) ? 1 : length_reg;
                if (m_eff > PATTERN_MAX)
                    m_eff = PATTERN_MAX;
                k_eff = (errors_reg > ERRORS_MAX) ? ERRORS_MAX : errors_reg;
                char_mask = '1;
                // bytes with the top bit set never match a 7-bit character
                if (!item.symbol[SYMBOL_W-1]) begin
                    for (int i = 0; i < m_eff; i++)
                        if (stored_chars[i] == item.symbol[CHAR_W-1:0])
                            char_mask[i] = 1'b0;
                end
                prev_row = mismatch_rows[0];
                mismatch_rows[0] = (mismatch_rows[0] | char_mask) << 1;
                for (int d = 1; d <= k_eff; d++) begin
                    cur_row = mismatch_rows[d];
                    mismatch_rows[d] = (prev_row & (cur_row | char_mask)) << 1;
                    prev_row = cur_row;
                end
                pos_now = text_pos;
                if (text_pos != '1)
                    text_pos = text_pos + 1'b1;
                if (!mismatch_rows[k_eff][m_eff]) begin
                    res.match_found = 1'b1;
                    res.match_start = pos_now - POS_W'(m_eff) + 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (stored_chars[i]) stored_chars[i] = '0;
            foreach (mismatch_rows[d]) mismatch_rows[d] = ROW_START;
            text_pos     = '0;
            length_reg   = LENGTH_W'(1);
            errors_reg   = '0;
            o_fail_count = 0;
            predicted_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_PATTERN_LENGTH)
                    length_reg = i_cfg_data[LENGTH_W-1:0];
                else if (i_cfg_idx == CFG_MAX_ERRORS)
                    errors_reg = i_cfg_data[ERRORS_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("%0t: result transfer with none pending: found=%b start=%0d",
                                 $time, i_out_data.match_found, i_out_data.match_start);
                    o_fail_count++;
                end else begin
                    oldest = predicted_results.pop_front();
                    if (i_out_data.match_found !== oldest.match_found ||
                            i_out_data.match_start !== oldest.match_start) begin
                        if (o_fail_count < 10)
                            $display("%0t: mismatch: found exp %b got %b, start exp %0d got %0d",
                                     $time, oldest.match_found, i_out_data.match_found,
                                     oldest.match_start, i_out_data.match_start);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                predicted_results.push_back(match_step(i_in_data));
        end
        o_pending = predicted_results.size();
    end

endmodule

>>> tb/sv/bitap_substitution_matcher_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bitap_substitution_matcher_tb: top level for the k-mismatch matcher
// Loads patterns, sets length and error limit over several phases including
// their extremes, and streams text built mostly from pattern copies with a
// controlled number of substitutions, mixed with noise. Sender bursts and
// receiver stalls vary throughout; the checker module does the comparison.
// ---------------------------------------------------------------------------
module bitap_substitution_matcher_tb;
    import bsm_pkg::*;

    localparam int PATTERN_MAX = 31;
    localparam int ERRORS_MAX  = 7;
    localparam int HALF_PERIOD = 5;
    localparam int ITEM_TARGET = 1950;
    localparam int DRAIN_LIMIT = 5000;
    localparam int LIMIT_NS    = 4_000_000;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = CFG_PATTERN_LENGTH;
    logic [CFG_W-1:0]     cfg_data  = '0;

    int unsigned fail_count;
    int unsigned pending;

    logic [CHAR_W-1:0] pattern [PATTERN_MAX];
    int unsigned       len_used   = 1;
    int unsigned       err_used   = 0;
    int unsigned       item_count = 0;
    int unsigned       burst_left = 0;
    logic              small_alpha = 1'b1;
    t_stall_mode       stall_mode = STALL_NONE;
    int unsigned       stall_run  = 0;

    bitap_substitution_matcher #(
        .PATTERN_MAX (PATTERN_MAX),
        .ERRORS_MAX  (ERRORS_MAX)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_data     (in_data),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_data     (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    bitap_substitution_matcher_checker #(
        .PATTERN_MAX (PATTERN_MAX),
        .ERRORS_MAX  (ERRORS_MAX)
    ) i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(HALF_PERIOD) clk = ~clk;

    initial begin
        #(LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    always @(posedge clk) begin
        if (stall_run == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_run  <= $urandom_range(16, 160);
        end else begin
            stall_run <= stall_run - 1;
        end
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= (stall_run % 4 != 0);
        endcase
    end

    function automatic int unsigned pick_char();
        if (!small_alpha)
            return $urandom_range(0, 127);
        case ($urandom_range(0, 3))
            0:       return "A";
            1:       return "C";
            2:       return "G";
            default: return "T";
        endcase
    endfunction

    // one input transfer; starts and returns at a rising edge
    task automatic send(input t_action act, input int unsigned idx, input int unsigned sym);
        t_in         item;
        logic        stalled;
        int unsigned gap;
        item.action        = act;
        item.pattern_index = INDEX_W'(idx);
        item.symbol        = SYMBOL_W'(sym);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: gap = 0;
                9:          gap = $urandom_range(10, 30);
                default:    gap = $urandom_range(1, 5);
            endcase
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end while (stalled);
        if (act == ACT_LOAD && item.pattern_index < PATTERN_MAX)
            pattern[item.pattern_index] = item.symbol[CHAR_W-1:0];
        if (act != ACT_NOP && !(act == ACT_LOAD && item.pattern_index >= PATTERN_MAX))
            item_count++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_config(input int unsigned len, input int unsigned err);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_PATTERN_LENGTH;
        cfg_data <= CFG_W'(len);
        @(posedge clk);
        cfg_idx  <= CFG_MAX_ERRORS;
        cfg_data <= CFG_W'(err);
        @(posedge clk);
        cfg_we   <= 1'b0;
        len_used = (len % 32 == 0) ? 1 : len % 32;
        err_used = err % 8;
    endtask

    // pattern copy with exactly subs substituted positions, or all if subs exceeds the length
    task automatic send_window(input int unsigned subs);
        int unsigned left;
        left = subs;
        for (int i = 0; i < len_used; i++) begin
            if (left != 0 && $urandom_range(0, len_used - 1 - i) < left) begin
                left--;
                if ($urandom_range(0, 3) == 0)
                    send(ACT_TEXT, $urandom, {1'b1, pattern[i]});
                else
                    send(ACT_TEXT, $urandom,
                         {1'b0, pattern[i] ^ CHAR_W'($urandom_range(1, 127))});
            end else begin
                send(ACT_TEXT, $urandom, {1'b0, pattern[i]});
            end
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned start_count;
        int unsigned text_goal;
        int unsigned sel;
        int unsigned settle;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: length 1, no substitutions
        send(ACT_LOAD, 0, "A");
        send(ACT_BEGIN, 0, 0);
        send(ACT_TEXT, 0, "A");
        send(ACT_TEXT, 0, "B");
        send(ACT_TEXT, 0, 8'h80 | "A");
        send(ACT_TEXT, 0, "A");
        send(ACT_NOP, PATTERN_MAX, 8'hFF);
        send(ACT_LOAD, PATTERN_MAX, 8'hFF);
        send(ACT_TEXT, PATTERN_MAX, "A");
        send(ACT_LOAD, 0, 8'h80);
        send(ACT_TEXT, 0, 8'h00);
        send(ACT_TEXT, 0, 8'hFF);
        send(ACT_TEXT, 0, 8'h80);
        send(ACT_BEGIN, $urandom, $urandom);
        send(ACT_TEXT, $urandom, 8'h00);
        send(ACT_TEXT, $urandom, 8'h00);

        phase = 0;
        while (item_count < ITEM_TARGET) begin
            drain();
            case (phase)
                0:       set_config(31, 7);
                1:       set_config(0, 7);
                2:       set_config(1, 0);
                3:       set_config(31, 0);
                default: set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                                : $urandom_range(1, 8),
                                    $urandom_range(0, 31));
            endcase
            small_alpha = ($urandom_range(0, 2) != 0);
            for (int i = 0; i < len_used; i++)
                send(ACT_LOAD, i, pick_char() | (($urandom_range(0, 3) == 0) ? 8'h80 : 8'h00));
            send(ACT_BEGIN, $urandom, $urandom);
            start_count = item_count;
            text_goal   = $urandom_range(40, 150);
            while (item_count - start_count < text_goal) begin
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    send_window($urandom_range(0, err_used + 1));
                else if (sel < 80)
                    repeat ($urandom_range(1, 6))
                        send(ACT_TEXT, $urandom,
                             ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : pick_char());
                else if (sel < 88)
                    send(ACT_NOP, $urandom, $urandom);
                else if (sel < 92)
                    send(ACT_LOAD, PATTERN_MAX, $urandom);
                else if (sel < 97)
                    send(ACT_LOAD, $urandom_range(0, PATTERN_MAX - 1), pick_char());
                else
                    send(ACT_BEGIN, $urandom, $urandom);
            end
            phase++;
        end

        in_valid <= 1'b0;
        settle = 0;
        do begin
            @(negedge clk);
            settle++;
        end while (pending != 0 && settle < DRAIN_LIMIT);
        repeat (4) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/bsm_pkg.sv
hw/rtl/bsm_char_cell.sv
hw/rtl/bsm_row_cell.sv
hw/rtl/bitap_substitution_matcher.sv
tb/sv/bitap_substitution_matcher_checker.sv
tb/sv/bitap_substitution_matcher_tb.sv
